[src/kwm_pkg.sv]
package kwm_pkg;

	// Sizing
	localparam int NUM_LISTS  = 8;
	localparam int LIST_DEPTH = 1024;
	localparam int KEY_BITS   = 32;

	localparam int LIST_W = $clog2(NUM_LISTS);
	localparam int POS_W  = $clog2(LIST_DEPTH);
	localparam int CNT_W  = POS_W + 1;
	localparam int ADDR_W = LIST_W + POS_W;
	localparam int TOT_W  = $clog2(NUM_LISTS * LIST_DEPTH + 1);

	// Request codes
	localparam logic REQ_APPEND = 1'b0;
	localparam logic REQ_TAKE   = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_APPENDED = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_TAKEN    = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	// One head presented to the compare unit
	typedef struct packed {
		logic                vld;
		logic [KEY_BITS-1:0] key;
		logic [LIST_W-1:0]   lst;
		logic [POS_W-1:0]    pos;
	} kwm_cand_t;

	// Running minimum held by the compare unit
	typedef struct packed {
		logic                found;
		logic [KEY_BITS-1:0] key;
		logic [LIST_W-1:0]   lst;
		logic [POS_W-1:0]    pos;
	} kwm_best_t;

endpackage

[src/kwm_req_if.sv]
interface kwm_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [2:0]  list_index;
	logic [31:0] seq_length;

	modport source (output valid, req_type, list_index, seq_length, input ready);
	modport sink (input valid, req_type, list_index, seq_length, output ready);
endinterface

[src/kwm_rsp_if.sv]
interface kwm_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [2:0]  source_list;
	logic [9:0]  source_position;
	logic [31:0] taken_length;

	modport source (output valid, status, source_list, source_position, taken_length,
		input ready);
	modport sink (input valid, status, source_list, source_position, taken_length,
		output ready);
endinterface

[src/kwm_key_store.sv]
module kwm_key_store (
	input  logic                          clk,
	input  logic                          we,
	input  logic [kwm_pkg::ADDR_W-1:0]   waddr,
	input  logic [kwm_pkg::KEY_BITS-1:0] wdata,
	input  logic [kwm_pkg::ADDR_W-1:0]   raddr,
	output logic [kwm_pkg::KEY_BITS-1:0] rdata
);

	// Key storage, one region of LIST_DEPTH entries per list
	logic [kwm_pkg::KEY_BITS-1:0] mem [kwm_pkg::NUM_LISTS * kwm_pkg::LIST_DEPTH];
	logic [kwm_pkg::KEY_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[src/kwm_min_unit.sv]
module kwm_min_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clr,
	input  kwm_pkg::kwm_cand_t cand,
	output kwm_pkg::kwm_best_t best
);

	logic                         found_q;
	logic [kwm_pkg::KEY_BITS-1:0] key_q;
	logic [kwm_pkg::LIST_W-1:0]   lst_q;
	logic [kwm_pkg::POS_W-1:0]    pos_q;
	logic                         take_cand;

	// Strict less-than: on a tie the earlier (lower) list stays
	assign take_cand = cand.vld && (!found_q || (cand.key < key_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (clr) begin
			found_q <= 1'b0;
		end else if (take_cand) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_cand && !clr) begin
			key_q <= cand.key;
			lst_q <= cand.lst;
			pos_q <= cand.pos;
		end
	end

	assign best.found = found_q;
	assign best.key   = key_q;
	assign best.lst   = lst_q;
	assign best.pos   = pos_q;

endmodule

[src/k_way_merge_by_length_unit.sv]
// K-way merge of length-keyed lists.
// Channels: req (sink) carries req_type, list_index and seq_length; rsp (source)
// carries status, source_list, source_position and taken_length. Every request
// transfer produces exactly one response transfer, in request order.
// Append: the key goes to the tail of list_index; a full list drops it and
// reports list full. The request is taken in idle; the result is registered
// from the append state once the output register is free.
// Take: a sequencer walks the eight list heads one per cycle through the key
// memory read port into a single shared compare unit (the read address of one
// head is issued while the head before it is compared), then updates the
// winner's read position as the result is written to the output register.
// Requests are accepted only while the sequencer is idle.
// Reset clears fill counts, read positions and the outstanding count at once;
// the key memory is not cleared and needs no sweep.
// A stalled receiver holds the result in the output register; the next request
// is still accepted and runs until its own result must be written, where it
// waits for the output register to free up.
module k_way_merge_by_length_unit (
	input  logic      clk,
	input  logic      arst_n,
	kwm_req_if.sink   req,
	kwm_rsp_if.source rsp
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_APPEND = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	localparam int LW = kwm_pkg::LIST_W;
	localparam int PW = kwm_pkg::POS_W;
	localparam int CW = kwm_pkg::CNT_W;
	localparam int KW = kwm_pkg::KEY_BITS;

	logic [1:0]             state_q;
	logic [LW:0]            cnt_q;
	logic [LW-1:0]          idx_q;
	logic [KW-1:0]          key_q;
	logic [CW-1:0]          fill_q [kwm_pkg::NUM_LISTS];
	logic [CW-1:0]          rpos_q [kwm_pkg::NUM_LISTS];
	logic [kwm_pkg::TOT_W-1:0] remaining_q;

	// Scan pipeline stage between memory read and compare
	logic                   hv_s1;
	logic [LW-1:0]          lst_s1;
	logic [PW-1:0]          pos_s1;

	logic                   out_valid_q;
	logic [1:0]             status_q;
	logic [2:0]             list_q;
	logic [9:0]             pos_q;
	logic [31:0]            taken_q;

	logic [LW-1:0]          sel_list;
	logic [CW-1:0]          fill_sel;
	logic [CW-1:0]          rpos_sel;
	logic                   head_vld;
	logic                   out_free;
	logic                   app_fire;
	logic                   done_fire;
	logic                   list_full;
	logic                   req_fire;
	logic                   clr_min;
	logic                   scan_issue;
	logic [KW-1:0]          rd_key;
	kwm_pkg::kwm_cand_t     cand;
	kwm_pkg::kwm_best_t     best;

	// Shared list-select: append target, scan counter or winning list
	always_comb begin
		unique case (state_q)
			ST_SCAN: sel_list = cnt_q[LW-1:0];
			ST_DONE: sel_list = best.lst;
			default: sel_list = idx_q;
		endcase
	end

	assign fill_sel   = fill_q[sel_list];
	assign rpos_sel   = rpos_q[sel_list];
	assign head_vld   = rpos_sel < fill_sel;
	assign list_full  = fill_sel[PW];
	assign out_free   = !out_valid_q || rsp.ready;
	assign req_fire   = req.valid && req.ready;
	assign app_fire   = (state_q == ST_APPEND) && out_free;
	assign done_fire  = (state_q == ST_DONE) && out_free;
	assign clr_min    = req_fire && (req.req_type == kwm_pkg::REQ_TAKE);
	assign scan_issue = (state_q == ST_SCAN) && !cnt_q[LW];

	assign req.ready  = (state_q == ST_IDLE);

	// Key memory: append writes, scan reads one head per cycle
	kwm_key_store u_store (
		.clk   (clk),
		.we    (app_fire && !list_full),
		.waddr ({idx_q, fill_sel[PW-1:0]}),
		.wdata (key_q),
		.raddr ({cnt_q[LW-1:0], rpos_sel[PW-1:0]}),
		.rdata (rd_key)
	);

	assign cand.vld = hv_s1;
	assign cand.key = rd_key;
	assign cand.lst = lst_s1;
	assign cand.pos = pos_s1;

	kwm_min_unit u_min (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (clr_min),
		.cand   (cand),
		.best   (best)
	);

	// Sequencer and list bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			hv_s1       <= 1'b0;
			remaining_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < kwm_pkg::NUM_LISTS; i++) begin
				fill_q[i] <= '0;
				rpos_q[i] <= '0;
			end
		end else begin
			hv_s1 <= scan_issue && head_vld;
			// Output register: loaded by a finishing request, freed by a transfer
			out_valid_q <= app_fire || done_fire || (out_valid_q && !rsp.ready);
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						cnt_q   <= '0;
						state_q <= (req.req_type == kwm_pkg::REQ_TAKE) ? ST_SCAN : ST_APPEND;
					end
				end
				ST_APPEND: begin
					if (out_free) begin
						if (!list_full) begin
							fill_q[sel_list] <= fill_sel + CW'(1);
							remaining_q      <= remaining_q + kwm_pkg::TOT_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + (LW+1)'(1);
					if (cnt_q[LW]) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						if (best.found) begin
							rpos_q[sel_list] <= rpos_sel + CW'(1);
							if (remaining_q != '0) begin
								remaining_q <= remaining_q - kwm_pkg::TOT_W'(1);
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			idx_q <= req.list_index[LW-1:0];
			key_q <= req.seq_length[KW-1:0];
		end
		if (scan_issue) begin
			lst_s1 <= cnt_q[LW-1:0];
			pos_s1 <= rpos_sel[PW-1:0];
		end
		if (app_fire) begin
			list_q  <= 3'(idx_q);
			taken_q <= '0;
			if (list_full) begin
				status_q <= kwm_pkg::ST_FULL;
				pos_q    <= '0;
			end else begin
				status_q <= kwm_pkg::ST_APPENDED;
				pos_q    <= 10'(fill_sel[PW-1:0]);
			end
		end else if (done_fire) begin
			if (best.found) begin
				status_q <= kwm_pkg::ST_TAKEN;
				list_q   <= 3'(best.lst);
				pos_q    <= 10'(best.pos);
				taken_q  <= 32'(best.key);
			end else begin
				status_q <= kwm_pkg::ST_EMPTY;
				list_q   <= '0;
				pos_q    <= '0;
				taken_q  <= '0;
			end
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = status_q;
	assign rsp.source_list     = list_q;
	assign rsp.source_position = pos_q;
	assign rsp.taken_length    = taken_q;

	// Compare stage is only live while the sequencer scans
	a_stage_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		hv_s1 |-> state_q == ST_SCAN)
		else $error("scan stage valid outside of scan");

	// Nothing left is only reported when no key is outstanding
	a_empty_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		done_fire && !best.found |-> remaining_q == '0)
		else $error("take found nothing while keys are outstanding");

	// A result is only written while the output register can take it
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(app_fire || done_fire) |=> out_valid_q)
		else $error("result lost on output register");

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
	import kwm_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 30;

	// One response as the block should present it
	typedef struct {
		logic [1:0]          status;
		logic [LIST_W-1:0]   source_list;
		logic [POS_W-1:0]    source_position;
		logic [KEY_BITS-1:0] taken_length;
	} merge_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	kwm_req_if req_ch();
	kwm_rsp_if rsp_ch();

	k_way_merge_by_length_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the list contents and positions
	logic [KEY_BITS-1:0] stored_keys [NUM_LISTS][LIST_DEPTH];
	int unsigned         fill_level [NUM_LISTS] = '{default: 0};
	int unsigned         head_pos [NUM_LISTS]   = '{default: 0};

	merge_rsp_t pending_rsp [$];
	int         fail_count   = 0;
	int         cycle_count  = 0;
	bit         req_gaps_on   = 1'b1;
	bit         rsp_stalls_on = 1'b1;
	int         rsp_hold_left = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Mostly short gaps, a few long ones
	function automatic int pick_gap(input bit enable);
		int r;
		r = $urandom_range(0, 99);
		if (!enable || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Next merge result, updating the shadow lists
	function automatic merge_rsp_t predict_merge(input logic rt, input logic [LIST_W-1:0] li,
		input logic [KEY_BITS-1:0] key);
		merge_rsp_t          r;
		bit                  found;
		int unsigned         best;
		logic [KEY_BITS-1:0] best_key;
		r = '{status: ST_EMPTY, source_list: '0, source_position: '0, taken_length: '0};
		found = 1'b0;
		best = 0;
		best_key = '0;
		if (rt == REQ_APPEND) begin
			r.source_list = li;
			if (fill_level[li] >= LIST_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				stored_keys[li][fill_level[li]] = key;
				r.status = ST_APPENDED;
				r.source_position = POS_W'(fill_level[li]);
				fill_level[li]++;
			end
		end else begin
			// lowest list wins a tie: strict compare only
			for (int i = 0; i < NUM_LISTS; i++) begin
				if (head_pos[i] < fill_level[i]) begin
					if (!found || stored_keys[i][head_pos[i]] < best_key) begin
						found = 1'b1;
						best = i;
						best_key = stored_keys[i][head_pos[i]];
					end
				end
			end
			if (found) begin
				r.status = ST_TAKEN;
				r.source_list = LIST_W'(best);
				r.source_position = POS_W'(head_pos[best]);
				r.taken_length = best_key;
				head_pos[best]++;
			end
		end
		return r;
	endfunction

	// Drive one request and record its expected response on transfer
	task automatic send_request(input logic rt, input logic [LIST_W-1:0] li,
		input logic [KEY_BITS-1:0] key);
		int gap;
		gap = pick_gap(req_gaps_on);
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= rt;
		req_ch.list_index <= li;
		req_ch.seq_length <= key;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		pending_rsp.insert(pending_rsp.size(), predict_merge(rt, li, key));
	endtask

	// Response side: random stalls plus an optional long hold-off
	initial begin : rsp_sink
		int stall_left;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				rsp_hold_left--;
			end else if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				stall_left = pick_gap(rsp_stalls_on);
			end
		end
	end

	// Compare each response transfer with the oldest expectation
	always @(posedge clk) begin : rsp_check
		merge_rsp_t exp_rsp;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_rsp.size() == 0) begin
				$error("response transfer with no request outstanding");
				fail_count++;
			end else begin
				exp_rsp = pending_rsp.pop_front();
				if (rsp_ch.status !== exp_rsp.status) begin
					$error("status: expected %0d, got %0d", exp_rsp.status, rsp_ch.status);
					fail_count++;
				end
				if (rsp_ch.source_list !== exp_rsp.source_list) begin
					$error("source_list: expected %0d, got %0d",
						exp_rsp.source_list, rsp_ch.source_list);
					fail_count++;
				end
				if (rsp_ch.source_position !== exp_rsp.source_position) begin
					$error("source_position: expected %0d, got %0d",
						exp_rsp.source_position, rsp_ch.source_position);
					fail_count++;
				end
				if (rsp_ch.taken_length !== exp_rsp.taken_length) begin
					$error("taken_length: expected %0h, got %0h",
						exp_rsp.taken_length, rsp_ch.taken_length);
					fail_count++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Take with every list empty reports nothing left
	task automatic test_empty_take();
		send_request(REQ_TAKE, 3'd0, 32'h0);
		send_request(REQ_TAKE, 3'd7, 32'hFFFF_FFFF);
	endtask

	// Extreme keys, ties between lists, an unsorted list, then drain it all
	task automatic test_merge_order();
		send_request(REQ_APPEND, 3'd0, 32'h0000_0000);
		send_request(REQ_APPEND, 3'd3, 32'h0000_0000);
		send_request(REQ_APPEND, 3'd7, 32'hFFFF_FFFF);
		send_request(REQ_APPEND, 3'd1, 32'h0000_0005);
		send_request(REQ_APPEND, 3'd2, 32'h0000_0032);
		send_request(REQ_APPEND, 3'd2, 32'h0000_000A);
		send_request(REQ_APPEND, 3'd4, 32'h0000_0005);
		send_request(REQ_APPEND, 3'd5, 32'hAAAA_AAAA);
		send_request(REQ_APPEND, 3'd6, 32'h5555_5555);
		repeat (10) send_request(REQ_TAKE, 3'd0, 32'h0);
	endtask

	// Fill one list to the top, then overflow it
	task automatic test_list_full();
		logic [KEY_BITS-1:0] key;
		key = $urandom_range(0, 1000);
		req_gaps_on = 1'b0;
		rsp_stalls_on = 1'b0;
		while (fill_level[5] < LIST_DEPTH) begin
			if (fill_level[5] == LIST_DEPTH / 2) begin
				req_gaps_on = 1'b1;
				rsp_stalls_on = 1'b1;
			end
			send_request(REQ_APPEND, 3'd5, key);
			key = key + $urandom_range(0, 4_000_000);
		end
		send_request(REQ_APPEND, 3'd5, 32'h0000_0000);
		send_request(REQ_APPEND, 3'd5, 32'hFFFF_FFFF);
		send_request(REQ_APPEND, 3'd5, $urandom);
	endtask

	// Receiver holds off while requests keep coming; the block must stall its input
	task automatic test_backpressure();
		rsp_hold_left = 300;
		req_gaps_on = 1'b0;
		for (int n = 0; n < 12; n++) begin
			if (n % 2 == 0)
				send_request(REQ_APPEND, LIST_W'($urandom_range(0, 7)), $urandom);
			else
				send_request(REQ_TAKE, '0, '0);
		end
		req_gaps_on = 1'b1;
	endtask

	// Mostly sorted appends per list mixed with takes; some unsorted noise
	task automatic test_random_merge(input int n_items);
		logic [KEY_BITS-1:0] last_key [NUM_LISTS];
		logic [KEY_BITS:0]   next_key;
		logic [KEY_BITS-1:0] key;
		logic [LIST_W-1:0]   li;
		for (int i = 0; i < NUM_LISTS; i++)
			last_key[i] = '0;
		for (int n = 0; n < n_items; n++) begin
			req_gaps_on = (n % 200) < 150;
			rsp_stalls_on = ((n + 100) % 200) < 150;
			li = LIST_W'($urandom_range(0, NUM_LISTS - 1));
			if ($urandom_range(0, 99) < 55) begin
				next_key = last_key[li] + $urandom_range(0, 1 << 26);
				if ($urandom_range(0, 9) == 0 || next_key[KEY_BITS]) begin
					key = $urandom;
				end else begin
					key = next_key[KEY_BITS-1:0];
					last_key[li] = key;
				end
				send_request(REQ_APPEND, li, key);
			end else begin
				// list and key are don't-care on a take
				send_request(REQ_TAKE, li, $urandom);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_APPEND;
		req_ch.list_index = '0;
		req_ch.seq_length = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_take();
		test_merge_order();
		test_list_full();
		test_backpressure();
		test_random_merge(850);

		@(negedge clk);
		req_ch.valid <= 1'b0;
		wait (pending_rsp.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
